FILE: rtl/gtr_pkg.sv
// Shared types, codes and the 5x8 font table of the glyph text rasterizer.
package gtr_pkg;

   localparam logic       OP_SET_CURSOR = 1'b0;
   localparam logic       OP_RENDER     = 1'b1;

   localparam logic [7:0] CODE_NEWLINE  = 8'h0a;
   localparam logic [7:0] CODE_CR       = 8'h0d;
   localparam logic [7:0] CODE_FIRST    = 8'h20;
   localparam logic [7:0] CODE_LAST     = 8'h7e;

   localparam logic [15:0] ADVANCE      = 16'd6;
   localparam logic [15:0] LINE_STEP    = 16'd8;
   localparam logic [2:0]  LAST_COL     = 3'd4;
   localparam logic [2:0]  LAST_ROW     = 3'd7;

   localparam logic        REG_TEXT_COLOR = 1'b0;
   localparam logic [15:0] COLOR_RESET    = 16'hffff;

   localparam int FONT_BYTES = 475;

   typedef struct packed {
      logic load;     // an item is taken from the input channel
      logic step;     // evaluate the current font cell and move to the next
      logic flush;    // send the held pixel out as the last one of the glyph
      logic advance;  // move the cursor one character cell to the right
   } cmd_type;

   typedef struct packed {
      logic printable;  // item on the input renders a drawable glyph
      logic hit;        // current font cell is lit and on screen
      logic pend_valid; // a pixel is held waiting for its successor
      logic out_free;   // output register can take a beat this cycle
      logic scan_last;  // current cell is the final one of the glyph
   } status_type;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h5f,8'h00,8'h00,8'h00,8'h07,8'h00,8'h07,
      8'h00,8'h14,8'h7f,8'h14,8'h7f,8'h14,8'h24,8'h2a,8'h7f,8'h2a,8'h12,8'h23,8'h13,8'h08,
      8'h64,8'h62,8'h36,8'h49,8'h56,8'h20,8'h50,8'h00,8'h08,8'h07,8'h03,8'h00,8'h00,8'h1c,
      8'h22,8'h41,8'h00,8'h00,8'h41,8'h22,8'h1c,8'h00,8'h2a,8'h1c,8'h7f,8'h1c,8'h2a,8'h08,
      8'h08,8'h3e,8'h08,8'h08,8'h00,8'h80,8'h70,8'h30,8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,
      8'h00,8'h00,8'h60,8'h60,8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,8'h3e,8'h51,8'h49,8'h45,
      8'h3e,8'h00,8'h42,8'h7f,8'h40,8'h00,8'h72,8'h49,8'h49,8'h49,8'h46,8'h21,8'h41,8'h49,
      8'h4d,8'h33,8'h18,8'h14,8'h12,8'h7f,8'h10,8'h27,8'h45,8'h45,8'h45,8'h39,8'h3c,8'h4a,
      8'h49,8'h49,8'h31,8'h41,8'h21,8'h11,8'h09,8'h07,8'h36,8'h49,8'h49,8'h49,8'h36,8'h46,
      8'h49,8'h49,8'h29,8'h1e,8'h00,8'h00,8'h14,8'h00,8'h00,8'h00,8'h40,8'h34,8'h00,8'h00,
      8'h00,8'h08,8'h14,8'h22,8'h41,8'h14,8'h14,8'h14,8'h14,8'h14,8'h00,8'h41,8'h22,8'h14,
      8'h08,8'h02,8'h01,8'h59,8'h09,8'h06,8'h3e,8'h41,8'h5d,8'h59,8'h4e,8'h7c,8'h12,8'h11,
      8'h12,8'h7c,8'h7f,8'h49,8'h49,8'h49,8'h36,8'h3e,8'h41,8'h41,8'h41,8'h22,8'h7f,8'h41,
      8'h41,8'h41,8'h3e,8'h7f,8'h49,8'h49,8'h49,8'h41,8'h7f,8'h09,8'h09,8'h09,8'h01,8'h3e,
      8'h41,8'h41,8'h51,8'h73,8'h7f,8'h08,8'h08,8'h08,8'h7f,8'h00,8'h41,8'h7f,8'h41,8'h00,
      8'h20,8'h40,8'h41,8'h3f,8'h01,8'h7f,8'h08,8'h14,8'h22,8'h41,8'h7f,8'h40,8'h40,8'h40,
      8'h40,8'h7f,8'h02,8'h1c,8'h02,8'h7f,8'h7f,8'h04,8'h08,8'h10,8'h7f,8'h3e,8'h41,8'h41,
      8'h41,8'h3e,8'h7f,8'h09,8'h09,8'h09,8'h06,8'h3e,8'h41,8'h51,8'h21,8'h5e,8'h7f,8'h09,
      8'h19,8'h29,8'h46,8'h26,8'h49,8'h49,8'h49,8'h32,8'h03,8'h01,8'h7f,8'h01,8'h03,8'h3f,
      8'h40,8'h40,8'h40,8'h3f,8'h1f,8'h20,8'h40,8'h20,8'h1f,8'h3f,8'h40,8'h38,8'h40,8'h3f,
      8'h63,8'h14,8'h08,8'h14,8'h63,8'h03,8'h04,8'h78,8'h04,8'h03,8'h61,8'h59,8'h49,8'h4d,
      8'h43,8'h00,8'h7f,8'h41,8'h41,8'h41,8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,8'h41,8'h41,
      8'h41,8'h7f,8'h04,8'h02,8'h01,8'h02,8'h04,8'h40,8'h40,8'h40,8'h40,8'h40,8'h00,8'h03,
      8'h07,8'h08,8'h00,8'h20,8'h54,8'h54,8'h78,8'h40,8'h7f,8'h28,8'h44,8'h44,8'h38,8'h38,
      8'h44,8'h44,8'h44,8'h28,8'h38,8'h44,8'h44,8'h28,8'h7f,8'h38,8'h54,8'h54,8'h54,8'h18,
      8'h00,8'h08,8'h7e,8'h09,8'h02,8'h18,8'ha4,8'ha4,8'h9c,8'h78,8'h7f,8'h08,8'h04,8'h04,
      8'h78,8'h00,8'h44,8'h7d,8'h40,8'h00,8'h20,8'h40,8'h40,8'h3d,8'h00,8'h7f,8'h10,8'h28,
      8'h44,8'h00,8'h00,8'h41,8'h7f,8'h40,8'h00,8'h7c,8'h04,8'h78,8'h04,8'h78,8'h7c,8'h08,
      8'h04,8'h04,8'h78,8'h38,8'h44,8'h44,8'h44,8'h38,8'hfc,8'h18,8'h24,8'h24,8'h18,8'h18,
      8'h24,8'h24,8'h18,8'hfc,8'h7c,8'h08,8'h04,8'h04,8'h08,8'h48,8'h54,8'h54,8'h54,8'h24,
      8'h04,8'h04,8'h3f,8'h44,8'h24,8'h3c,8'h40,8'h40,8'h20,8'h7c,8'h1c,8'h20,8'h40,8'h20,
      8'h1c,8'h3c,8'h40,8'h30,8'h40,8'h3c,8'h44,8'h28,8'h10,8'h28,8'h44,8'h4c,8'h90,8'h90,
      8'h90,8'h7c,8'h44,8'h64,8'h54,8'h4c,8'h44,8'h00,8'h08,8'h36,8'h41,8'h00,8'h00,8'h00,
      8'h77,8'h00,8'h00,8'h00,8'h41,8'h36,8'h08,8'h00,8'h02,8'h01,8'h02,8'h04,8'h02
   };

endpackage

FILE: rtl/gtr_csr.sv
// Configuration register block holding the text color.
module gtr_csr
   import gtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] text_color
);

   logic [15:0] text_color_ff;
   logic [15:0] text_color_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_TEXT_COLOR);

   always_comb begin
      text_color_in = text_color_ff;
      if (wr_en) begin
         text_color_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_TEXT_COLOR) ? {16'd0, text_color_ff} : 32'd0;
   assign text_color = text_color_ff;

endmodule

FILE: rtl/gtr_ctrl.sv
// Sequencing state machine: takes items, steps the glyph scan and ends each glyph.
module gtr_ctrl
   import gtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       stall;

   assign stall = status.hit && status.pend_valid && !status.out_free;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (status.printable) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               cmd.step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush   = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gtr_datapath.sv
// Cursor, glyph scan counters, pixel clipping, held pixel and output register.
module gtr_datapath
   import gtr_pkg::*;
#(
   parameter int SCREEN_SIZE = 240
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_op,
   input  logic [15:0] req_pos_x,
   input  logic [15:0] req_pos_y,
   input  logic [7:0]  req_char_code,
   input  logic [15:0] text_color,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [15:0] SCREEN_LIM = 16'(SCREEN_SIZE);

   logic [15:0] cur_col_ff, cur_col_in;
   logic [15:0] cur_row_ff, cur_row_in;
   logic [8:0]  base_ff, base_in;
   logic [2:0]  col_ff, col_in;
   logic [2:0]  row_ff, row_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_x_ff, pend_x_in;
   logic [7:0]  pend_y_ff, pend_y_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_x_ff, out_x_in;
   logic [7:0]  out_y_ff, out_y_in;
   logic [15:0] out_color_ff, out_color_in;
   logic        out_last_ff, out_last_in;

   logic        printable;
   logic [6:0]  glyph_num;
   logic [8:0]  rom_idx;
   logic [7:0]  font_bits;
   logic [15:0] px, py;
   logic        on_x, on_y;
   logic        hit;
   logic        out_free;
   logic        push_mid;
   logic        push;

   assign printable = (req_op == OP_RENDER) && (req_char_code >= CODE_FIRST)
                      && (req_char_code <= CODE_LAST);
   assign glyph_num = 7'(req_char_code - CODE_FIRST);

   // Glyph byte for the current column; the row bit selects the cell.
   assign rom_idx   = base_ff + {6'd0, col_ff};
   assign font_bits = FONT_ROM[rom_idx];

   assign px   = cur_col_ff + {13'd0, col_ff};
   assign py   = cur_row_ff + {13'd0, row_ff};
   assign on_x = !px[15] && (px < SCREEN_LIM);
   assign on_y = !py[15] && (py < SCREEN_LIM);
   assign hit  = font_bits[row_ff] && on_x && on_y;

   assign out_free = !out_valid_ff || rsp_tready;
   assign push_mid = cmd.step && hit && pend_valid_ff;
   assign push     = push_mid || cmd.flush;

   assign status.printable  = printable;
   assign status.hit        = hit;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;
   assign status.scan_last  = (col_ff == LAST_COL) && (row_ff == LAST_ROW);

   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      base_in       = base_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;

      if (cmd.load) begin
         if (req_op == OP_SET_CURSOR) begin
            cur_col_in = req_pos_x;
            cur_row_in = req_pos_y;
         end else if (req_char_code == CODE_NEWLINE) begin
            cur_col_in = 16'd0;
            cur_row_in = cur_row_ff + LINE_STEP;
         end else if (req_char_code == CODE_CR) begin
            cur_col_in = cur_col_ff;
         end else if (printable) begin
            base_in       = {glyph_num, 2'b00} + {2'b00, glyph_num};
            col_in        = 3'd0;
            row_in        = 3'd0;
            pend_valid_in = 1'b0;
         end else begin
            cur_col_in = cur_col_ff + ADVANCE;
         end
      end

      if (cmd.step) begin
         if (row_ff == LAST_ROW) begin
            row_in = 3'd0;
            col_in = col_ff + 3'd1;
         end else begin
            row_in = row_ff + 3'd1;
         end
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_x_in     = px[7:0];
            pend_y_in     = py[7:0];
         end
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      if (cmd.advance) begin
         cur_col_in = cur_col_ff + ADVANCE;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_x_in     = pend_x_ff;
         out_y_in     = pend_y_ff;
         out_color_in = text_color;
         out_last_in  = cmd.flush;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= 16'd0;
         cur_row_ff    <= 16'd0;
         col_ff        <= 3'd0;
         row_ff        <= 3'd0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_color_ff, out_y_ff, out_x_ff};
   assign rsp_tlast  = out_last_ff;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("pixel pushed over an unconsumed output beat");

   a_flush_held: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> pend_valid_ff)
      else $error("glyph flush without a held pixel");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (col_ff <= LAST_COL))
      else $error("glyph scan ran past the last column");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (!pend_valid_ff && out_valid_ff && out_last_ff))
      else $error("flush did not leave a last-pixel beat");

endmodule

FILE: rtl/glyph_text_rasterizer_top.sv
// Top level of the 5x8 bitmap font text rasterizer.
// A set-cursor, newline, carriage-return or undrawable item is done as it is accepted.
// A printable glyph is accepted, its 40 font cells are scanned one a cycle, then it is flushed;
// the scan stalls while a lit cell meets a held pixel and the result side holds back a beat.
// A lit pixel is held back and leaves as a beat when the next lit cell or the flush comes.
// Synchronous active-high reset clears the cursor to (0,0), the color to white, the
// scan state and the output register; no clearing pass is needed.
module glyph_text_rasterizer_top
   import gtr_pkg::*;
#(
   parameter int SCREEN_SIZE = 240
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel, one beat per item.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // pos_x[15:0], pos_y[31:16], char_code[39:32]
   input  logic        req_tuser,  // op (0 set cursor, 1 render character)
   // Result channel, one beat per lit pixel on screen.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // pixel_x[7:0], pixel_y[15:8], pixel_color[31:16]
   output logic        rsp_tlast,  // last_pixel of the glyph
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type     cmd;
   status_type  status;
   logic [15:0] text_color;

   // Register block, color only; the user must write it only while the engine is idle, unenforced.
   gtr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .text_color  (text_color)
   );

   // The controller decides when items are taken and when the scan moves on.
   gtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds one lit pixel back so that the final one can carry the last flag;
   // the output register lets the scan run on, up to the next lit cell, while a beat waits.
   gtr_datapath #(
      .SCREEN_SIZE (SCREEN_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_tuser),
      .req_pos_x     (req_tdata[15:0]),
      .req_pos_y     (req_tdata[31:16]),
      .req_char_code (req_tdata[39:32]),
      .text_color    (text_color),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

FILE: dv/glyph_text_rasterizer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the 5x8 glyph text rasterizer: stream stimulus, pixel scoreboard.
module glyph_text_rasterizer_top_tb
   import gtr_pkg::*;
();

   // Screen edge used by both the block and the pixel predictor.
   localparam int SCREEN = 240;
   // A glyph with nothing on screen keeps the block busy for its whole scan
   // without giving any beat, so idle waits leave this margin for it to finish.
   localparam int SETTLE = 60;
   // Length of the long result-side hold that backs the block up.
   localparam int HOLD_OFF = 300;
   // Cycles without any handshake after which the run is declared hung.
   localparam int WATCHDOG = 3000;

   // One expected pixel beat on the result channel.
   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] color;
      logic        last;
   } pixel_type;

   // The scoreboard keeps its own text cursor and color and turns every
   // accepted item into the pixels the block should emit for it.
   class pixel_board_type;
      logic [15:0] color;
      logic [15:0] col;
      logic [15:0] row;
      pixel_type   due[$];
      int unsigned mismatches;

      function new();
         color      = COLOR_RESET;
         col        = '0;
         row        = '0;
         mismatches = 0;
      endfunction

      // Only the first ten mismatches are printed; all of them are counted.
      function void flag(string msg);
         if (mismatches < 10) begin
            $display("MISMATCH at %0t: %s", $time, msg);
         end
         mismatches++;
      endfunction

      // A wrapped 16-bit coordinate is drawn only if it is non-negative and on screen.
      function bit visible(logic [15:0] v);
         return !v[15] && (v < SCREEN);
      endfunction

      function int pending();
         return due.size();
      endfunction

      // Called at the edge where an input beat is accepted.
      function void take_item(logic op, logic [15:0] new_col, logic [15:0] new_row,
                              logic [7:0] code);
         pixel_type   glyph[$];
         pixel_type   p;
         logic [7:0]  bits;
         logic [15:0] px;
         logic [15:0] py;
         int          base;
         if (op == OP_SET_CURSOR) begin
            col = new_col;
            row = new_row;
            return;
         end
         if (code == CODE_NEWLINE) begin
            col = '0;
            row = row + LINE_STEP;
            return;
         end
         // A carriage return neither draws nor moves the cursor.
         if (code == CODE_CR) begin
            return;
         end
         if (code >= CODE_FIRST && code <= CODE_LAST) begin
            base = (int'(code) - int'(CODE_FIRST)) * (int'(LAST_COL) + 1);
            // Column-major scan: columns outer, rows inner, bit 0 is the top row.
            for (int c = 0; c <= int'(LAST_COL); c++) begin
               bits = FONT_ROM[base + c];
               px   = col + 16'(c);
               for (int r = 0; r <= int'(LAST_ROW); r++) begin
                  py = row + 16'(r);
                  if (bits[r] && visible(px) && visible(py)) begin
                     p.x     = px[7:0];
                     p.y     = py[7:0];
                     p.color = color;
                     p.last  = 1'b0;
                     glyph.insert(glyph.size(), p);
                  end
               end
            end
            // A glyph with nothing on screen gives no beat and so no last flag.
            if (glyph.size() > 0) begin
               glyph[glyph.size() - 1].last = 1'b1;
            end
            foreach (glyph[i]) begin
               due.insert(due.size(), glyph[i]);
            end
         end
         // Printable and undrawable codes alike move the cursor one cell right.
         col = col + ADVANCE;
      endfunction

      // Called at the edge where a result beat is accepted.
      function void check_pixel(logic [31:0] data, logic last);
         pixel_type want;
         if (due.size() == 0) begin
            flag($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                           data[7:0], data[15:8], data[31:16], last));
            return;
         end
         want = due.pop_front();
         if (data[7:0] != want.x) begin
            flag($sformatf("pixel_x expected %0d, got %0d", want.x, data[7:0]));
         end
         if (data[15:8] != want.y) begin
            flag($sformatf("pixel_y expected %0d, got %0d", want.y, data[15:8]));
         end
         if (data[31:16] != want.color) begin
            flag($sformatf("pixel_color expected %h, got %h", want.color, data[31:16]));
         end
         if (last != want.last) begin
            flag($sformatf("last_pixel expected %b, got %b", want.last, last));
         end
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // pos_x[15:0], pos_y[31:16], char_code[39:32]
   logic        req_tuser   = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // pixel_x[7:0], pixel_y[15:8], pixel_color[31:16]
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_board_type board;
   // When set, neither side inserts idle cycles between beats.
   bit          steady_flow  = 1'b0;
   // A nonzero value asks the result side for one long hold of that many cycles.
   int          hold_request = 0;
   int          quiet_cycles = 0;

   glyph_text_rasterizer_top #(
      .SCREEN_SIZE(SCREEN)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   // The watchdog restarts whenever any beat or register access moves, so
   // only a block that stops answering altogether ends the run here.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
         $display("glyph_text_rasterizer_top_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: before each beat it idles a random number of cycles, or
   // takes the long hold when one has been asked for. Ready is changed at the
   // falling edge only, and the beat is taken at the rising edge.
   initial begin : pixel_sink
      int gap;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            gap          = hold_request;
            hold_request = 0;
         end else begin
            gap = steady_flow ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
         board.check_pixel(rsp_tdata, rsp_tlast);
      end
   end

   // Offers one item, starting and ending at a falling edge. Valid is only
   // lowered when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_item(input logic op, input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] code);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {code, y, x};
      do @(posedge clock); while (!req_tready);
      board.take_item(op, x, y, code);
      @(negedge clock);
   endtask

   // The field an item ignores is filled at random so that its bits move too.
   task automatic set_cursor(input logic [15:0] x, input logic [15:0] y);
      send_item(OP_SET_CURSOR, x, y, 8'($urandom));
   endtask

   task automatic put_char(input logic [7:0] code);
      send_item(OP_RENDER, 16'($urandom), 16'($urandom), code);
   endtask

   // Mostly well-formed text: cursor moves near the screen, printable glyphs
   // and line breaks, with a share of wild cursors and arbitrary codes.
   task automatic send_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         set_cursor(16'($urandom_range(0, 255) - 8), 16'($urandom_range(0, 255) - 8));
      end else if (pick < 20) begin
         set_cursor(16'($urandom), 16'($urandom));
      end else if (pick < 80) begin
         put_char(8'($urandom_range(CODE_FIRST, CODE_LAST)));
      end else if (pick < 88) begin
         put_char(CODE_NEWLINE);
      end else if (pick < 91) begin
         put_char(CODE_CR);
      end else begin
         put_char(8'($urandom));
      end
   endtask

   // Stops offering and waits until every expected pixel has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // One register access: a setup phase, then the access phase that completes
   // at the rising edge with pready high.
   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {REG_TEXT_COLOR, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (write) begin
         board.color = wdata[15:0];
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // The color only changes with the block idle: all pixels in, and enough
   // cycles for a glyph that draws nothing to finish its scan. The value is
   // read back afterwards; the upper write bits are noise the block drops.
   task automatic set_color(input logic [15:0] value);
      logic [31:0] rd;
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_access(1'b1, {16'($urandom), value}, rd);
      csr_access(1'b0, 32'($urandom), rd);
      if (rd[15:0] != value) begin
         board.flag($sformatf("text_color read back %h, written %h", rd[15:0], value));
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed part, drawn in the reset color. It starts from the reset
      // cursor and covers both ends of the printable range, the line
      // controls, undrawable codes on both sides of the printable range,
      // glyphs clipped at every screen edge, cursors at the 16-bit extremes
      // and a newline that carries the row from negative to zero.
      put_char(8'h41);
      put_char(CODE_LAST);
      put_char(CODE_CR);
      put_char(CODE_NEWLINE);
      put_char(CODE_FIRST);
      put_char(8'h00);
      put_char(8'h1f);
      put_char(8'h7f);
      put_char(8'hff);
      set_cursor(-16'sd3, -16'sd2);
      put_char(8'h23);
      set_cursor(16'd236, 16'd234);
      put_char(8'h67);
      set_cursor(16'h8000, 16'h8000);
      put_char(8'h57);
      set_cursor(16'h7fff, 16'h7fff);
      put_char(8'h4d);
      set_cursor(-16'sd4, 16'd100);
      put_char(8'h48);
      put_char(8'h69);
      set_cursor(16'd120, 16'hfff0);
      put_char(CODE_NEWLINE);
      put_char(CODE_NEWLINE);
      put_char(8'h5f);

      // Random text in black with idling on both sides.
      set_color(16'h0000);
      repeat (25) send_random();

      // A random color, and the long hold: a few dense glyphs first so that
      // the block backs up and stalls its input while the hold lasts. Midway
      // the sender stops until every pixel has come back.
      set_color(16'($urandom));
      hold_request = HOLD_OFF;
      set_cursor(16'd0, 16'd40);
      repeat (4) put_char(8'h4d);
      repeat (12) send_random();
      drain();
      repeat (15) send_random();

      // White again, with neither side idling.
      set_color(16'hffff);
      steady_flow = 1'b1;
      repeat (25) send_random();
      steady_flow = 1'b0;

      // One more random color with idling.
      set_color(16'($urandom));
      repeat (4) send_random();

      // Wait for the last pixels and let a trailing blank glyph finish.
      drain();
      repeat (SETTLE) @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("glyph_text_rasterizer_top_tb: done, clean");
      end else begin
         $display("glyph_text_rasterizer_top_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/gtr_pkg.sv
rtl/gtr_csr.sv
rtl/gtr_ctrl.sv
rtl/gtr_datapath.sv
rtl/glyph_text_rasterizer_top.sv
dv/glyph_text_rasterizer_top_tb.sv
